@@ src/tsd_pkg.sv @@
package tsd_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned HDR_IDX_W   = 5;
   localparam int unsigned DIM_W       = 16;
   localparam int unsigned PIXELS_W    = 32;
   localparam int unsigned COLOR_W     = 24;
   localparam int unsigned RSP_DATA_W  = 80;
   localparam int unsigned RSP_FIELD_W = 75;

   localparam logic [HDR_IDX_W-1:0] HDR_TYPE_IDX  = 5'd2;
   localparam logic [HDR_IDX_W-1:0] HDR_FIXED_LEN = 5'd12;
   localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [HDR_IDX_W-1:0] HDR_DEPTH     = 5'd16;
   localparam logic [HDR_IDX_W-1:0] HDR_DESC      = 5'd17;

   localparam logic [DATA_W-1:0] TYPE_RAW    = 8'd2;
   localparam logic [DATA_W-1:0] TYPE_RLE    = 8'd10;
   localparam logic [DATA_W-1:0] DEPTH_24    = 8'd24;
   localparam logic [DATA_W-1:0] DEPTH_32    = 8'd32;
   localparam logic [DATA_W-1:0] RUN_FLAG    = 8'd128;
   localparam logic [DATA_W-1:0] RUN_OFFSET  = 8'd127;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_RAW,
      PH_PKT_HDR,
      PH_PKT_RAW,
      PH_RUN,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_INFO,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_TYPE,
      ERR_SIZE,
      ERR_OVERFLOW
   } err_type;

   typedef struct packed {
      kind_type          kind;
      err_type           error_code;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
      logic [7:0]        repeat_res;
      logic              last_pixel;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
      logic              has_alpha;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_beat_type;

endpackage

@@ src/tsd_core.sv @@
module tsd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_accept,
   input  logic [tsd_pkg::DATA_W-1:0]  in_byte,
   input  logic                        in_start,
   output tsd_pkg::rsp_beat_type       result
);
   import tsd_pkg::*;

   phase_type              phase_ff, phase_in, phase_cur;
   logic [HDR_IDX_W-1:0]   hdr_idx_ff, hdr_idx_in, hdr_idx_cur;
   logic                   is_rle_ff, is_rle_in, is_rle_cur;
   logic [DIM_W-1:0]       width_ff, width_in, width_cur;
   logic [DIM_W-1:0]       height_ff, height_in, height_cur;
   logic                   four_ff, four_in, four_cur;
   logic [PIXELS_W-1:0]    pixels_ff, pixels_in, pixels_cur;
   logic [7:0]             packet_ff, packet_in, packet_cur;
   logic [1:0]             pbi_ff, pbi_in, pbi_cur;
   logic [COLOR_W-1:0]     color_ff, color_in, color_cur;

   logic                   px_done;
   logic [COLOR_W-1:0]     color_new;
   logic [1:0]             pbi_new;
   logic [7:0]             alpha_new;
   logic [PIXELS_W-1:0]    pix_dec;
   logic [7:0]             pkt_dec;
   logic [7:0]             run_rep;
   logic                   run_clip;
   logic [PIXELS_W-1:0]    run_left;
   logic                   hdr_ok;
   logic                   size_bad;
   rsp_item_type           pixel_item;

   // A file start clears the parser before the byte is taken.
   always_comb begin
      phase_cur   = in_start ? PH_HEADER : phase_ff;
      hdr_idx_cur = in_start ? '0 : hdr_idx_ff;
      is_rle_cur  = in_start ? 1'b0 : is_rle_ff;
      width_cur   = in_start ? '0 : width_ff;
      height_cur  = in_start ? '0 : height_ff;
      four_cur    = in_start ? 1'b0 : four_ff;
      pixels_cur  = in_start ? '0 : pixels_ff;
      packet_cur  = in_start ? '0 : packet_ff;
      pbi_cur     = in_start ? '0 : pbi_ff;
      color_cur   = in_start ? '0 : color_ff;
   end

   always_comb begin
      unique case (pbi_cur)
         2'd0: color_new = {16'h0000, in_byte};
         2'd1: color_new = color_cur | {8'h00, in_byte, 8'h00};
         2'd2: color_new = color_cur | {in_byte, 16'h0000};
         2'd3: color_new = color_cur;
         default: color_new = color_cur;
      endcase
      px_done   = four_cur ? (pbi_cur == 2'd3) : (pbi_cur >= 2'd2);
      pbi_new   = px_done ? 2'd0 : pbi_cur + 2'd1;
      alpha_new = four_cur ? in_byte : 8'h00;
      pix_dec   = pixels_cur - {{(PIXELS_W-1){1'b0}}, 1'b1};
      pkt_dec   = packet_cur - 8'd1;
      run_clip  = {{(PIXELS_W-8){1'b0}}, packet_cur} > pixels_cur;
      run_rep   = run_clip ? pixels_cur[7:0] : packet_cur;
      run_left  = pixels_cur - {{(PIXELS_W-8){1'b0}}, run_rep};
      hdr_ok    = (hdr_idx_cur == HDR_TYPE_IDX) ? (in_byte == TYPE_RAW || in_byte == TYPE_RLE)
                                                : (in_byte == 8'h00);
      size_bad  = (width_cur == '0) || (height_cur == '0) ||
                  (in_byte != DEPTH_24 && in_byte != DEPTH_32);

      pixel_item              = '0;
      pixel_item.kind         = KIND_PIXEL;
      pixel_item.error_code   = ERR_NONE;
      pixel_item.red          = color_new[23:16];
      pixel_item.green        = color_new[15:8];
      pixel_item.blue         = color_new[7:0];
      pixel_item.alpha        = alpha_new;
      pixel_item.repeat_res   = 8'd1;
      pixel_item.has_alpha    = four_cur;
   end

   always_comb begin
      phase_in   = phase_cur;
      hdr_idx_in = hdr_idx_cur;
      is_rle_in  = is_rle_cur;
      width_in   = width_cur;
      height_in  = height_cur;
      four_in    = four_cur;
      pixels_in  = pixels_cur;
      packet_in  = packet_cur;
      pbi_in     = pbi_cur;
      color_in   = color_cur;
      result     = '0;

      unique case (phase_cur)
         PH_HEADER: begin
            if (hdr_idx_cur < HDR_FIXED_LEN) begin
               if (hdr_idx_cur == HDR_TYPE_IDX) begin
                  is_rle_in = (in_byte == TYPE_RLE);
               end
               if (!hdr_ok) begin
                  phase_in                = PH_ERROR;
                  result.valid            = 1'b1;
                  result.item.kind        = KIND_ERROR;
                  result.item.error_code  = ERR_TYPE;
               end else begin
                  hdr_idx_in = hdr_idx_cur + 5'd1;
               end
            end else if (hdr_idx_cur == HDR_WIDTH_LO) begin
               width_in   = {8'h00, in_byte};
               hdr_idx_in = HDR_WIDTH_HI;
            end else if (hdr_idx_cur == HDR_WIDTH_HI) begin
               width_in   = width_cur | {in_byte, 8'h00};
               hdr_idx_in = HDR_HEIGHT_LO;
            end else if (hdr_idx_cur == HDR_HEIGHT_LO) begin
               height_in  = {8'h00, in_byte};
               hdr_idx_in = HDR_HEIGHT_HI;
            end else if (hdr_idx_cur == HDR_HEIGHT_HI) begin
               height_in  = height_cur | {in_byte, 8'h00};
               hdr_idx_in = HDR_DEPTH;
            end else if (hdr_idx_cur == HDR_DEPTH) begin
               four_in      = (in_byte == DEPTH_32);
               result.valid = 1'b1;
               if (size_bad) begin
                  phase_in               = PH_ERROR;
                  result.item.kind       = KIND_ERROR;
                  result.item.error_code = ERR_SIZE;
               end else begin
                  pixels_in                = {{(PIXELS_W-DIM_W){1'b0}}, width_cur} *
                                             {{(PIXELS_W-DIM_W){1'b0}}, height_cur};
                  hdr_idx_in               = HDR_DESC;
                  result.item.kind         = KIND_INFO;
                  result.item.image_width  = width_cur;
                  result.item.image_height = height_cur;
                  result.item.has_alpha    = (in_byte == DEPTH_32);
               end
            end else begin
               phase_in = is_rle_cur ? PH_PKT_HDR : PH_RAW;
               pbi_in   = '0;
            end
         end
         PH_RAW: begin
            pbi_in   = pbi_new;
            color_in = color_new;
            if (px_done) begin
               pixels_in                  = pix_dec;
               result.valid               = 1'b1;
               result.item                = pixel_item;
               result.item.last_pixel     = (pix_dec == '0);
               if (pix_dec == '0) begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_PKT_HDR: begin
            pbi_in = '0;
            if (in_byte < RUN_FLAG) begin
               packet_in = in_byte + 8'd1;
               phase_in  = PH_PKT_RAW;
            end else begin
               packet_in = in_byte - RUN_OFFSET;
               phase_in  = PH_RUN;
            end
         end
         PH_PKT_RAW: begin
            pbi_in   = pbi_new;
            color_in = color_new;
            if (px_done) begin
               pixels_in              = pix_dec;
               packet_in              = pkt_dec;
               result.valid           = 1'b1;
               result.item            = pixel_item;
               result.item.last_pixel = (pix_dec == '0);
               if (pix_dec == '0) begin
                  phase_in = PH_DONE;
                  if (pkt_dec != 8'd0) begin
                     result.item.error_code = ERR_OVERFLOW;
                  end
               end else if (pkt_dec == 8'd0) begin
                  phase_in = PH_PKT_HDR;
               end
            end
         end
         PH_RUN: begin
            pbi_in   = pbi_new;
            color_in = color_new;
            if (px_done) begin
               pixels_in              = run_left;
               packet_in              = 8'd0;
               phase_in               = (run_left == '0) ? PH_DONE : PH_PKT_HDR;
               result.valid           = 1'b1;
               result.item            = pixel_item;
               result.item.repeat_res = run_rep;
               result.item.last_pixel = (run_left == '0);
               result.item.error_code = run_clip ? ERR_OVERFLOW : ERR_NONE;
            end
         end
         PH_DONE, PH_ERROR: begin
         end
         default: begin
         end
      endcase

      if (!in_accept) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= '0;
         is_rle_ff  <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
         four_ff    <= 1'b0;
         pixels_ff  <= '0;
         packet_ff  <= '0;
         pbi_ff     <= '0;
         color_ff   <= '0;
      end else if (in_accept) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         is_rle_ff  <= is_rle_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         four_ff    <= four_in;
         pixels_ff  <= pixels_in;
         packet_ff  <= packet_in;
         pbi_ff     <= pbi_in;
         color_ff   <= color_in;
      end
   end

endmodule

@@ src/tsd_out_buf.sv @@
module tsd_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  tsd_pkg::rsp_beat_type  load,
   output logic                   load_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tsd_pkg::rsp_item_type  out_item
);
   import tsd_pkg::*;

   logic         full_ff;
   rsp_item_type item_ff;

   assign load_ready = !full_ff || out_ready;
   assign out_valid  = full_ff;
   assign out_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (load.valid) begin
         full_ff <= 1'b1;
      end else if (out_ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         item_ff <= load.item;
      end
   end

endmodule

@@ src/tga_stream_decoder_top.sv @@
// Streaming decoder for true-color TGA files, type 2 (raw) and type 10 (RLE), at 24 or 32
// bits per pixel. The file enters one byte per transaction, and a new byte is taken in every
// cycle: each byte is decoded by the parser in the cycle it is accepted, and any result lands
// in a single output register, so a byte gives its result in the next cycle. The input stalls
// only while that register is full and the result is not being taken. Raise the start flag
// on the first byte of each file. One info transaction is produced by the depth byte, the
// seventeenth of the 18-byte header; pixels then come one per transaction, and an RLE run
// comes as a single transaction with its repeat count. Errors stop decoding until the next
// file start.
module tga_stream_decoder_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // file_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // error_code, red, green, blue, alpha, repeat_res, image_width, image_height,
   // has_alpha, zero fill
   output logic [79:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast    // last_pixel
);
   import tsd_pkg::*;

   logic         accept;
   rsp_beat_type beat;
   rsp_item_type item;

   assign accept = req_tvalid && req_tready;

   tsd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_tdata),
      .in_start  (req_tuser),
      .result    (beat)
   );

   tsd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (beat),
      .load_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (item)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tlast = item.last_pixel;
   assign rsp_tdata = {{(RSP_DATA_W-RSP_FIELD_W){1'b0}},
                       item.has_alpha,
                       item.image_height,
                       item.image_width,
                       item.repeat_res,
                       item.alpha,
                       item.blue,
                       item.green,
                       item.red,
                       item.error_code};

endmodule

@@ src/tsd_checker.sv @@
module tsd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import tsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input accepted while the output register is blocked.");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PIXEL && rsp_tdata[41:34] != 8'd0)
      else $error("Image end on a result that is not a pixel.");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |->
         (rsp_tdata[1:0] == ERR_TYPE || rsp_tdata[1:0] == ERR_SIZE) && !rsp_tlast)
      else $error("Error result with a bad code.");

   a_overflow_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PIXEL && rsp_tdata[1:0] == ERR_OVERFLOW |-> rsp_tlast)
      else $error("Clipped packet on a result that does not end the image.");

endmodule

bind tga_stream_decoder_top tsd_checker u_checker (.*);

@@ test/tb_tga_stream_decoder_top.sv @@
module tb_tga_stream_decoder_top;
   import tsd_pkg::*;

   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   tga_stream_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Decoder state as seen by the predictor.
   phase_type      dec_phase     = PH_HEADER;
   logic [4:0]     hdr_pos       = '0;
   logic           rle_mode      = 1'b0;
   logic [15:0]    img_w         = '0;
   logic [15:0]    img_h         = '0;
   logic           depth32       = 1'b0;
   logic [31:0]    px_remaining  = '0;
   logic [7:0]     pkt_remaining = '0;
   logic [1:0]     byte_pos      = '0;
   logic [23:0]    bgr_acc       = '0;

   rsp_item_type   awaited_results[$];
   int             bytes_decoded = 0;
   int             mismatches    = 0;
   int             snd_idle_pct  = 38;
   int             rcv_idle_pct  = 58;
   int             hold_ticket   = 0;
   int             hold_seen     = 0;
   int             hold_left     = 0;
   int             idle_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic string describe(input rsp_item_type r);
      return $sformatf({"kind %0d err %0d rgba %02h %02h %02h %02h rep %0d last %0b ",
                        "size %0dx%0d alpha %0b"},
                       r.kind, r.error_code, r.red, r.green, r.blue, r.alpha, r.repeat_res,
                       r.last_pixel, r.image_width, r.image_height, r.has_alpha);
   endfunction

   function automatic void push_result(input kind_type k, input err_type e,
                                       input logic [23:0] bgr, input logic [7:0] a,
                                       input logic [7:0] rep, input logic last,
                                       input logic [15:0] w, input logic [15:0] h,
                                       input logic ha);
      rsp_item_type r;
      r.kind         = k;
      r.error_code   = e;
      r.red          = bgr[23:16];
      r.green        = bgr[15:8];
      r.blue         = bgr[7:0];
      r.alpha        = a;
      r.repeat_res   = rep;
      r.last_pixel   = last;
      r.image_width  = w;
      r.image_height = h;
      r.has_alpha    = ha;
      awaited_results.push_back(r);
   endfunction

   // Gathers one stored color byte; returns 1 once the pixel is complete.
   function automatic logic take_pixel_byte(input logic [7:0] b, output logic [7:0] alpha_out);
      alpha_out = 8'h00;
      if (byte_pos == 2'd0) bgr_acc = '0;
      if (byte_pos != 2'd3) bgr_acc[8*byte_pos +: 8] = b;
      if (byte_pos == (depth32 ? 2'd3 : 2'd2)) begin
         byte_pos  = 2'd0;
         alpha_out = depth32 ? b : 8'h00;
         return 1'b1;
      end
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic first);
      logic [7:0]  alpha_byte;
      logic [31:0] run_len;
      err_type     err;
      logic        last;
      if (first) begin
         dec_phase     = PH_HEADER;
         hdr_pos       = '0;
         rle_mode      = 1'b0;
         img_w         = '0;
         img_h         = '0;
         depth32       = 1'b0;
         px_remaining  = '0;
         pkt_remaining = '0;
         byte_pos      = '0;
         bgr_acc       = '0;
      end
      if (dec_phase != PH_DONE && dec_phase != PH_ERROR) bytes_decoded++;
      err = ERR_NONE;
      case (dec_phase)
         PH_HEADER: begin
            if (hdr_pos < HDR_FIXED_LEN) begin
               if (hdr_pos == HDR_TYPE_IDX) rle_mode = (b == TYPE_RLE);
               if (hdr_pos == HDR_TYPE_IDX ? (b != TYPE_RAW && b != TYPE_RLE) : (b != 8'h00)) begin
                  dec_phase = PH_ERROR;
                  push_result(KIND_ERROR, ERR_TYPE, '0, '0, '0, 1'b0, '0, '0, 1'b0);
               end else begin
                  hdr_pos = hdr_pos + 5'd1;
               end
            end else if (hdr_pos == HDR_WIDTH_LO) begin
               img_w   = {8'h00, b};
               hdr_pos = HDR_WIDTH_HI;
            end else if (hdr_pos == HDR_WIDTH_HI) begin
               img_w[15:8] = b;
               hdr_pos     = HDR_HEIGHT_LO;
            end else if (hdr_pos == HDR_HEIGHT_LO) begin
               img_h   = {8'h00, b};
               hdr_pos = HDR_HEIGHT_HI;
            end else if (hdr_pos == HDR_HEIGHT_HI) begin
               img_h[15:8] = b;
               hdr_pos     = HDR_DEPTH;
            end else if (hdr_pos == HDR_DEPTH) begin
               depth32 = (b == DEPTH_32);
               if (img_w == 16'd0 || img_h == 16'd0 || (b != DEPTH_24 && b != DEPTH_32)) begin
                  dec_phase = PH_ERROR;
                  push_result(KIND_ERROR, ERR_SIZE, '0, '0, '0, 1'b0, '0, '0, 1'b0);
               end else begin
                  px_remaining = 32'(img_w) * 32'(img_h);
                  hdr_pos      = HDR_DESC;
                  push_result(KIND_INFO, ERR_NONE, '0, '0, '0, 1'b0, img_w, img_h, depth32);
               end
            end else begin
               dec_phase = rle_mode ? PH_PKT_HDR : PH_RAW;
               byte_pos  = '0;
            end
         end
         PH_RAW: begin
            if (take_pixel_byte(b, alpha_byte)) begin
               px_remaining = px_remaining - 32'd1;
               last         = (px_remaining == 32'd0);
               if (last) dec_phase = PH_DONE;
               push_result(KIND_PIXEL, ERR_NONE, bgr_acc, alpha_byte, 8'd1, last, '0, '0, depth32);
            end
         end
         PH_PKT_HDR: begin
            if (b < RUN_FLAG) begin
               pkt_remaining = b + 8'd1;
               dec_phase     = PH_PKT_RAW;
            end else begin
               pkt_remaining = b - RUN_OFFSET;
               dec_phase     = PH_RUN;
            end
            byte_pos = '0;
         end
         PH_PKT_RAW: begin
            if (take_pixel_byte(b, alpha_byte)) begin
               px_remaining  = px_remaining - 32'd1;
               pkt_remaining = pkt_remaining - 8'd1;
               last          = (px_remaining == 32'd0);
               if (last) begin
                  if (pkt_remaining != 8'd0) err = ERR_OVERFLOW;
                  dec_phase = PH_DONE;
               end else if (pkt_remaining == 8'd0) begin
                  dec_phase = PH_PKT_HDR;
               end
               push_result(KIND_PIXEL, err, bgr_acc, alpha_byte, 8'd1, last, '0, '0, depth32);
            end
         end
         PH_RUN: begin
            if (take_pixel_byte(b, alpha_byte)) begin
               run_len = {24'h0, pkt_remaining};
               if (run_len > px_remaining) begin
                  run_len = px_remaining;
                  err     = ERR_OVERFLOW;
               end
               px_remaining  = px_remaining - run_len;
               pkt_remaining = 8'd0;
               last          = (px_remaining == 32'd0);
               dec_phase     = last ? PH_DONE : PH_PKT_HDR;
               push_result(KIND_PIXEL, err, bgr_acc, alpha_byte, run_len[7:0], last, '0, '0,
                           depth32);
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(value, first);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_header(input logic [7:0] tga_type, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(tga_type, 1'b0);
      repeat (9) send_byte(8'h00, 1'b0);
      send_byte(w[7:0], 1'b0);
      send_byte(w[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(h[15:8], 1'b0);
      send_byte(depth, 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_color(input logic d32);
      repeat (d32 ? 4 : 3) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_image(input logic rle, input logic [15:0] w, input logic [15:0] h,
                             input logic d32, input int unsigned max_units);
      int unsigned left;
      int unsigned n;
      int unsigned taken;
      int unsigned units;
      send_header(rle ? TYPE_RLE : TYPE_RAW, w, h, d32 ? DEPTH_32 : DEPTH_24);
      left  = 32'(w) * 32'(h);
      units = 0;
      while (left > 0 && units < max_units) begin
         units++;
         if (!rle) begin
            send_color(d32);
            left--;
         end else begin
            n     = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            taken = (n < left) ? n : left;
            if ($urandom_range(1) == 1) begin
               send_byte(RUN_OFFSET + 8'(n), 1'b0);
               send_color(d32);
            end else begin
               send_byte(8'(n - 1), 1'b0);
               repeat (taken) send_color(d32);
            end
            left -= taken;
         end
      end
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   task automatic send_random_file();
      int          r;
      int          pos;
      logic [7:0]  bad;
      logic [7:0]  depth;
      logic [15:0] w;
      logic [15:0] h;
      r = $urandom_range(99);
      if (r < 6) begin
         pos = $urandom_range(11);
         for (int i = 0; i < pos; i++) begin
            send_byte((i == HDR_TYPE_IDX) ? ($urandom_range(1) ? TYPE_RLE : TYPE_RAW) : 8'h00,
                      i == 0);
         end
         if (pos == HDR_TYPE_IDX) begin
            bad = 8'($urandom_range(255));
            if (bad == TYPE_RAW || bad == TYPE_RLE) bad = bad + 8'd1;
         end else begin
            bad = 8'($urandom_range(1, 255));
         end
         send_byte(bad, pos == 0);
         repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
      end else if (r < 12) begin
         w     = 16'($urandom_range(1, 65535));
         h     = 16'($urandom_range(1, 65535));
         depth = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
         case ($urandom_range(2))
            0: w = 16'd0;
            1: h = 16'd0;
            default: begin
               depth = 8'($urandom_range(255));
               if (depth == DEPTH_24 || depth == DEPTH_32) depth = depth + 8'd1;
            end
         endcase
         send_header($urandom_range(1) ? TYPE_RLE : TYPE_RAW, w, h, depth);
      end else if (r < 15) begin
         send_image(1'($urandom_range(1)), 16'($urandom_range(1, 65535)),
                    16'($urandom_range(1, 65535)), 1'($urandom_range(1)),
                    $urandom_range(1, 12));
      end else begin
         send_image(1'($urandom_range(1)), 16'($urandom_range(1, 5)),
                    16'($urandom_range(1, 3)), 1'($urandom_range(1)), 32'hFFFF_FFFF);
      end
   endtask

   task automatic test_no_start();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   task automatic test_bad_type();
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'd3, 1'b0);
   endtask

   task automatic test_bad_size();
      send_header(TYPE_RAW, 16'hFFFF, 16'h0000, DEPTH_32);
   endtask

   task automatic test_raw_extremes();
      send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_32);
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   task automatic test_rle_clip();
      send_header(TYPE_RLE, 16'd2, 16'd1, DEPTH_24);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      wait_drain();
   endtask

   task automatic test_backpressure();
      snd_idle_pct = 0;
      hold_ticket <= hold_ticket + 1;
      send_image(1'b0, 16'd3, 16'd3, 1'b0, 32'hFFFF_FFFF);
      wait_drain();
   endtask

   task automatic test_random(input int snd_pct, input int rcv_pct, input int count);
      int target;
      snd_idle_pct = snd_pct;
      rcv_idle_pct <= rcv_pct;
      target = bytes_decoded + count;
      while (bytes_decoded < target) send_random_file();
      wait_drain();
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      logic         bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind         = kind_type'(rsp_tuser);
         got.error_code   = err_type'(rsp_tdata[1:0]);
         got.red          = rsp_tdata[9:2];
         got.green        = rsp_tdata[17:10];
         got.blue         = rsp_tdata[25:18];
         got.alpha        = rsp_tdata[33:26];
         got.repeat_res   = rsp_tdata[41:34];
         got.last_pixel   = rsp_tlast;
         got.image_width  = rsp_tdata[57:42];
         got.image_height = rsp_tdata[73:58];
         got.has_alpha    = rsp_tdata[74];
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected transaction: %s", describe(got));
            end
         end else begin
            want = awaited_results.pop_front();
            bad  = (got.kind !== want.kind) || (got.error_code !== want.error_code) ||
                   (got.red !== want.red) || (got.green !== want.green) ||
                   (got.blue !== want.blue) || (got.alpha !== want.alpha) ||
                   (got.repeat_res !== want.repeat_res) ||
                   (got.last_pixel !== want.last_pixel) ||
                   (got.image_width !== want.image_width) ||
                   (got.image_height !== want.image_height) ||
                   (got.has_alpha !== want.has_alpha) || (rsp_tdata[79:75] !== 5'b0);
            if (bad) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("mismatch expected: %s", describe(want));
                  $display("mismatch actual:   %s pad %02h", describe(got), rsp_tdata[79:75]);
               end
            end
         end
      end
      if (hold_ticket != hold_seen) begin
         hold_seen  <= hold_ticket;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_no_start();
      test_bad_type();
      test_bad_size();
      test_raw_extremes();
      test_rle_clip();
      test_backpressure();
      test_random(38, 58, 225);
      test_random(58, 38, 225);
      test_random(0, 0, 225);
      if (awaited_results.size() != 0) begin
         $display("%0d expected transactions never arrived", awaited_results.size());
      end
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
